// ----- src/cau_pkg.sv -----
package cau_pkg;

    localparam int FRACTION_BITS_DEF = 16;

    localparam logic [2:0] CMD_ADD = 3'd0;
    localparam logic [2:0] CMD_SUB = 3'd1;
    localparam logic [2:0] CMD_MUL = 3'd2;
    localparam logic [2:0] CMD_DIV = 3'd3;
    localparam logic [2:0] CMD_MAG = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DIV_ZERO = 2'd1;
    localparam logic [1:0] ST_SAT      = 2'd2;

    // Quotient bits kept by the divider, and the width of its partial remainder.
    localparam int QBITS    = 34;
    localparam int REMW     = 64 + QBITS;
    localparam int SQ_STEPS = 32;

    typedef struct packed {
        logic [2:0]  cmd;
        logic [31:0] dir_re;
        logic [31:0] dir_im;
        logic        dir_sat;
        logic        dz;
        logic        re_neg;
        logic        im_neg;
        logic [63:0] re_mag;
        logic [63:0] im_mag;
        logic [63:0] den;
    } cau_front_t;

    typedef struct packed {
        logic [2:0]       cmd;
        logic [31:0]      dir_re;
        logic [31:0]      dir_im;
        logic             dir_sat;
        logic             dz;
        logic             re_neg;
        logic             im_neg;
        logic             re_ovf;
        logic             im_ovf;
        logic [QBITS-1:0] re_q;
        logic [QBITS-1:0] im_q;
        logic [63:0]      sq_rem;
        logic [63:0]      sq_root;
    } cau_core_t;

    // Returns {saturated, word} for a sign and magnitude.
    function automatic logic [32:0] sat_pack(input logic neg, input logic [63:0] mag);
        logic [32:0] r;
        if (!neg)
        begin
            if (mag > 64'h7FFF_FFFF)
                r = {1'b1, 32'h7FFF_FFFF};
            else
                r = {1'b0, mag[31:0]};
        end
        else
        begin
            if (mag > 64'h8000_0000)
                r = {1'b1, 32'h8000_0000};
            else
                r = {1'b0, ~mag[31:0] + 32'd1};
        end
        return r;
    endfunction

endpackage

// ----- src/cau_front.sv -----
module cau_front #(
    parameter int FRACTION_BITS = cau_pkg::FRACTION_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          in_cmd,
    input  logic signed [31:0]  in_ar,
    input  logic signed [31:0]  in_ai,
    input  logic signed [31:0]  in_br,
    input  logic signed [31:0]  in_bi,
    output logic                out_valid,
    input  logic                out_ready,
    output cau_pkg::cau_front_t out_data
);
    import cau_pkg::*;

    localparam logic [63:0] HALF = 64'd1 << (FRACTION_BITS - 1);

    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;
    logic en1, en2, en3, en4, en5;

    logic [2:0]         s1_cmd_reg;
    logic signed [31:0] s1_ar_reg, s1_ai_reg, s1_br_reg, s1_bi_reg;

    logic [2:0]         s2_cmd_reg;
    logic signed [63:0] s2_p1_reg, s2_p2_reg, s2_p3_reg, s2_p4_reg, s2_p5_reg, s2_p6_reg;
    logic [31:0]        s2_as_re_reg, s2_as_im_reg;
    logic               s2_as_sat_reg;
    logic signed [31:0] mb1, mb2;
    logic [32:0]        sum_re, sum_im;
    logic [31:0]        as_re_next, as_im_next;
    logic               as_sat_next;

    logic [2:0]         s3_cmd_reg;
    logic [31:0]        s3_as_re_reg, s3_as_im_reg;
    logic               s3_as_sat_reg;
    logic [64:0]        s3_nre_reg, s3_nim_reg;
    logic [63:0]        s3_den_reg;

    logic [2:0]         s4_cmd_reg;
    logic [31:0]        s4_as_re_reg, s4_as_im_reg;
    logic               s4_as_sat_reg;
    logic               s4_re_neg_reg, s4_im_neg_reg;
    logic [63:0]        s4_re_mag_reg, s4_im_mag_reg, s4_den_reg;

    cau_front_t         s5_reg, s5_next;
    logic [63:0]        rnd_re, rnd_im;
    logic [32:0]        pk_re, pk_im;

    assign en5      = !v5_reg || out_ready;
    assign en4      = !v4_reg || en5;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
            if (en5) v5_reg <= v4_reg;
        end
    end

    always_comb
    begin
        mb1    = (s1_cmd_reg == CMD_MAG) ? s1_ar_reg : s1_br_reg;
        mb2    = (s1_cmd_reg == CMD_MAG) ? s1_ai_reg : s1_bi_reg;
        if (s1_cmd_reg == CMD_SUB)
        begin
            sum_re = {s1_ar_reg[31], s1_ar_reg} - {s1_br_reg[31], s1_br_reg};
            sum_im = {s1_ai_reg[31], s1_ai_reg} - {s1_bi_reg[31], s1_bi_reg};
        end
        else
        begin
            sum_re = {s1_ar_reg[31], s1_ar_reg} + {s1_br_reg[31], s1_br_reg};
            sum_im = {s1_ai_reg[31], s1_ai_reg} + {s1_bi_reg[31], s1_bi_reg};
        end
        as_re_next = (sum_re[32] != sum_re[31]) ?
                     (sum_re[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : sum_re[31:0];
        as_im_next = (sum_im[32] != sum_im[31]) ?
                     (sum_im[32] ? 32'h8000_0000 : 32'h7FFF_FFFF) : sum_im[31:0];
        as_sat_next = (sum_re[32] != sum_re[31]) || (sum_im[32] != sum_im[31]);
    end

    always_comb
    begin
        rnd_re = (s4_re_mag_reg + HALF) >> FRACTION_BITS;
        rnd_im = (s4_im_mag_reg + HALF) >> FRACTION_BITS;
        pk_re  = sat_pack(s4_re_neg_reg, rnd_re);
        pk_im  = sat_pack(s4_im_neg_reg, rnd_im);
        s5_next.cmd    = s4_cmd_reg;
        s5_next.dz     = (s4_den_reg == 64'd0);
        s5_next.re_neg = s4_re_neg_reg;
        s5_next.im_neg = s4_im_neg_reg;
        s5_next.re_mag = s4_re_mag_reg;
        s5_next.im_mag = s4_im_mag_reg;
        s5_next.den    = s4_den_reg;
        unique case (s4_cmd_reg)
            CMD_ADD, CMD_SUB:
            begin
                s5_next.dir_re  = s4_as_re_reg;
                s5_next.dir_im  = s4_as_im_reg;
                s5_next.dir_sat = s4_as_sat_reg;
            end
            CMD_MUL:
            begin
                s5_next.dir_re  = pk_re[31:0];
                s5_next.dir_im  = pk_im[31:0];
                s5_next.dir_sat = pk_re[32] || pk_im[32];
            end
            default:
            begin
                s5_next.dir_re  = 32'd0;
                s5_next.dir_im  = 32'd0;
                s5_next.dir_sat = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_cmd_reg <= in_cmd;
            s1_ar_reg  <= in_ar;
            s1_ai_reg  <= in_ai;
            s1_br_reg  <= in_br;
            s1_bi_reg  <= in_bi;
        end
        if (en2)
        begin
            s2_cmd_reg    <= s1_cmd_reg;
            s2_p1_reg     <= s1_ar_reg * mb1;
            s2_p2_reg     <= s1_ai_reg * mb2;
            s2_p3_reg     <= s1_ai_reg * s1_br_reg;
            s2_p4_reg     <= s1_ar_reg * s1_bi_reg;
            s2_p5_reg     <= s1_br_reg * s1_br_reg;
            s2_p6_reg     <= s1_bi_reg * s1_bi_reg;
            s2_as_re_reg  <= as_re_next;
            s2_as_im_reg  <= as_im_next;
            s2_as_sat_reg <= as_sat_next;
        end
        if (en3)
        begin
            s3_cmd_reg    <= s2_cmd_reg;
            s3_as_re_reg  <= s2_as_re_reg;
            s3_as_im_reg  <= s2_as_im_reg;
            s3_as_sat_reg <= s2_as_sat_reg;
            if (s2_cmd_reg == CMD_MUL)
            begin
                s3_nre_reg <= {s2_p1_reg[63], s2_p1_reg} - {s2_p2_reg[63], s2_p2_reg};
                s3_nim_reg <= {s2_p3_reg[63], s2_p3_reg} + {s2_p4_reg[63], s2_p4_reg};
            end
            else
            begin
                s3_nre_reg <= {s2_p1_reg[63], s2_p1_reg} + {s2_p2_reg[63], s2_p2_reg};
                s3_nim_reg <= {s2_p3_reg[63], s2_p3_reg} - {s2_p4_reg[63], s2_p4_reg};
            end
            s3_den_reg <= 64'(s2_p5_reg) + 64'(s2_p6_reg);
        end
        if (en4)
        begin
            s4_cmd_reg    <= s3_cmd_reg;
            s4_as_re_reg  <= s3_as_re_reg;
            s4_as_im_reg  <= s3_as_im_reg;
            s4_as_sat_reg <= s3_as_sat_reg;
            s4_re_neg_reg <= s3_nre_reg[64];
            s4_im_neg_reg <= s3_nim_reg[64];
            s4_re_mag_reg <= s3_nre_reg[64] ? 64'(~s3_nre_reg + 65'd1) : s3_nre_reg[63:0];
            s4_im_mag_reg <= s3_nim_reg[64] ? 64'(~s3_nim_reg + 65'd1) : s3_nim_reg[63:0];
            s4_den_reg    <= s3_den_reg;
        end
        if (en5)
        begin
            s5_reg <= s5_next;
        end
    end

    assign out_valid = v5_reg;
    assign out_data  = s5_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (v1_reg && v2_reg && v3_reg && v4_reg && v5_reg))
        else $error("Front end stalled with an empty stage.");

endmodule

// ----- src/cau_core.sv -----
module cau_core #(
    parameter int FRACTION_BITS = cau_pkg::FRACTION_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  cau_pkg::cau_front_t in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output cau_pkg::cau_core_t  out_data
);
    import cau_pkg::*;

    localparam int NST = QBITS;

    typedef struct packed {
        cau_core_t       res;
        logic [REMW-1:0] re_rem;
        logic [REMW-1:0] im_rem;
        logic [63:0]     den;
    } iter_t;

    iter_t        st_reg  [0:NST];
    iter_t        st_next [0:NST];
    logic [NST:0] v_reg;
    logic [NST+1:0] adv;

    assign adv[NST+1] = out_ready;

    genvar k;
    generate
        for (k = 0; k <= NST; k++)
        begin : g_stage
            assign adv[k] = !v_reg[k] || adv[k+1];
            if (k == 0)
            begin : g_init
                always_comb
                begin
                    logic [REMW-1:0] nre_w, nim_w, den_top;
                    nre_w   = REMW'(in_data.re_mag) << (FRACTION_BITS + 1);
                    nim_w   = REMW'(in_data.im_mag) << (FRACTION_BITS + 1);
                    den_top = REMW'(in_data.den) << QBITS;
                    st_next[0].res.cmd     = in_data.cmd;
                    st_next[0].res.dir_re  = in_data.dir_re;
                    st_next[0].res.dir_im  = in_data.dir_im;
                    st_next[0].res.dir_sat = in_data.dir_sat;
                    st_next[0].res.dz      = in_data.dz;
                    st_next[0].res.re_neg  = in_data.re_neg;
                    st_next[0].res.im_neg  = in_data.im_neg;
                    st_next[0].res.re_ovf  = (nre_w >= den_top);
                    st_next[0].res.im_ovf  = (nim_w >= den_top);
                    st_next[0].res.re_q    = '0;
                    st_next[0].res.im_q    = '0;
                    st_next[0].res.sq_rem  = in_data.re_mag;
                    st_next[0].res.sq_root = 64'd0;
                    st_next[0].re_rem      = nre_w;
                    st_next[0].im_rem      = nim_w;
                    st_next[0].den         = in_data.den;
                end
            end
            else
            begin : g_step
                localparam int BP = QBITS - k;
                always_comb
                begin
                    logic [REMW-1:0] dsh;
                    logic [63:0]     bitv, trial;
                    st_next[k] = st_reg[k-1];
                    dsh = REMW'(st_reg[k-1].den) << BP;
                    if (st_reg[k-1].re_rem >= dsh)
                    begin
                        st_next[k].re_rem      = st_reg[k-1].re_rem - dsh;
                        st_next[k].res.re_q[BP] = 1'b1;
                    end
                    if (st_reg[k-1].im_rem >= dsh)
                    begin
                        st_next[k].im_rem      = st_reg[k-1].im_rem - dsh;
                        st_next[k].res.im_q[BP] = 1'b1;
                    end
                    bitv  = (k <= SQ_STEPS) ? (64'd1 << (64 - 2 * k)) : 64'd0;
                    trial = st_reg[k-1].res.sq_root + bitv;
                    if (k <= SQ_STEPS)
                    begin
                        if (st_reg[k-1].res.sq_rem >= trial)
                        begin
                            st_next[k].res.sq_rem  = st_reg[k-1].res.sq_rem - trial;
                            st_next[k].res.sq_root = (st_reg[k-1].res.sq_root >> 1) + bitv;
                        end
                        else
                        begin
                            st_next[k].res.sq_root = st_reg[k-1].res.sq_root >> 1;
                        end
                    end
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[0]) v_reg[0] <= in_valid;
            for (int i = 1; i <= NST; i++)
            begin
                if (adv[i]) v_reg[i] <= v_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i <= NST; i++)
        begin
            if (adv[i]) st_reg[i] <= st_next[i];
        end
    end

    assign in_ready  = adv[0];
    assign out_valid = v_reg[NST];
    assign out_data  = st_reg[NST].res;

    assert property (@(posedge clk) disable iff (!rst_n)
        (v_reg[NST] && !out_ready) |=> (v_reg[NST] && $stable(st_reg[NST])))
        else $error("Last divider stage changed while stalled.");

endmodule

// ----- src/cau_back.sv -----
module cau_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  cau_pkg::cau_core_t in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [31:0]        result_real,
    output logic [31:0]        result_imag,
    output logic [1:0]         status
);
    import cau_pkg::*;

    logic        v1_reg, v2_reg, en1, en2;
    logic [2:0]  b1_cmd_reg;
    logic [31:0] b1_dir_re_reg, b1_dir_im_reg;
    logic        b1_dir_sat_reg, b1_dz_reg, b1_re_neg_reg, b1_im_neg_reg;
    logic [63:0] b1_div_re_reg, b1_div_im_reg, b1_sq_reg;

    logic [2:0]  b2_cmd_reg;
    logic [31:0] b2_re_reg, b2_im_reg, re_next, im_next;
    logic [1:0]  b2_status_reg, status_next;
    logic [32:0] pk_re, pk_im, pk_sq;

    assign en2      = !v2_reg || out_ready;
    assign en1      = !v1_reg || en2;
    assign in_ready = en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (en1) v1_reg <= in_valid;
            if (en2) v2_reg <= v1_reg;
        end
    end

    always_comb
    begin
        pk_re = sat_pack(b1_re_neg_reg, b1_div_re_reg);
        pk_im = sat_pack(b1_im_neg_reg, b1_div_im_reg);
        pk_sq = sat_pack(1'b0, b1_sq_reg);
        unique case (b1_cmd_reg)
            CMD_DIV:
            begin
                if (b1_dz_reg)
                begin
                    re_next     = 32'd0;
                    im_next     = 32'd0;
                    status_next = ST_DIV_ZERO;
                end
                else
                begin
                    re_next     = pk_re[31:0];
                    im_next     = pk_im[31:0];
                    status_next = (pk_re[32] || pk_im[32]) ? ST_SAT : ST_OK;
                end
            end
            CMD_MAG:
            begin
                re_next     = pk_sq[31:0];
                im_next     = 32'd0;
                status_next = pk_sq[32] ? ST_SAT : ST_OK;
            end
            default:
            begin
                re_next     = b1_dir_re_reg;
                im_next     = b1_dir_im_reg;
                status_next = b1_dir_sat_reg ? ST_SAT : ST_OK;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            b1_cmd_reg     <= in_data.cmd;
            b1_dir_re_reg  <= in_data.dir_re;
            b1_dir_im_reg  <= in_data.dir_im;
            b1_dir_sat_reg <= in_data.dir_sat;
            b1_dz_reg      <= in_data.dz;
            b1_re_neg_reg  <= in_data.re_neg;
            b1_im_neg_reg  <= in_data.im_neg;
            b1_div_re_reg  <= in_data.re_ovf ? 64'hFFFF_FFFF_FFFF_FFFF :
                              64'((35'(in_data.re_q) + 35'd1) >> 1);
            b1_div_im_reg  <= in_data.im_ovf ? 64'hFFFF_FFFF_FFFF_FFFF :
                              64'((35'(in_data.im_q) + 35'd1) >> 1);
            b1_sq_reg      <= in_data.sq_root +
                              64'(in_data.sq_rem > in_data.sq_root);
        end
        if (en2)
        begin
            b2_cmd_reg    <= b1_cmd_reg;
            b2_re_reg     <= re_next;
            b2_im_reg     <= im_next;
            b2_status_reg <= status_next;
        end
    end

    assign out_valid   = v2_reg;
    assign result_real = b2_re_reg;
    assign result_imag = b2_im_reg;
    assign status      = b2_status_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && b2_status_reg == ST_DIV_ZERO) |-> (b2_re_reg == 32'd0 && b2_im_reg == 32'd0))
        else $error("Divide by zero returned nonzero parts.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (v2_reg && b2_cmd_reg == CMD_MAG) |-> (b2_im_reg == 32'd0 && b2_status_reg != ST_DIV_ZERO))
        else $error("Magnitude result has an imaginary part or a divide flag.");

endmodule

// ----- src/complex_arithmetic_unit.sv -----
// Complex arithmetic unit on signed fixed-point operands with FRACTION_BITS
// fraction bits. A request arrives on the s_ channel: s_tuser holds the command
// (add, subtract, multiply, divide, magnitude of A) and s_tdata holds A and B.
// Each request gives exactly one result on the m_ channel: m_tdata holds the
// real and imaginary parts and m_tuser the status (ok, divide by zero, saturated).
// A request is taken on every edge where tvalid and tready are both high, so a
// new request can enter every cycle and, while m_tready stays high, the unit
// sustains one result per cycle. A request passes 42 register stages, the first
// loaded at its accepting edge: five stages of operand registers, multipliers and
// sign handling, 35 stages of the pipelined restoring divider (a set-up stage,
// then one quotient bit per stage, with the square root taking one root bit per
// stage alongside it until the root is complete), and two stages of rounding and
// output. Reset clears all valid bits, so the pipeline comes up empty and m_tvalid
// low. When m_tready is low the results hold in place; upstream stages still take
// new requests until every stage is full, and only then s_tready drops.
module complex_arithmetic_unit #(
    parameter int FRACTION_BITS = cau_pkg::FRACTION_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [127:0] s_tdata,   // a_real, a_imag, b_real, b_imag
    input  logic [2:0]   s_tuser,   // command
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [63:0]  m_tdata,   // result_real, result_imag
    output logic [1:0]   m_tuser    // status
);
    import cau_pkg::*;

    logic       f_valid, f_ready, c_valid, c_ready;
    cau_front_t f_data;
    cau_core_t  c_data;
    logic [31:0] result_real, result_imag;

    cau_front #(.FRACTION_BITS(FRACTION_BITS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cmd    (s_tuser),
        .in_ar     (s_tdata[31:0]),
        .in_ai     (s_tdata[63:32]),
        .in_br     (s_tdata[95:64]),
        .in_bi     (s_tdata[127:96]),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_data  (f_data)
    );

    cau_core #(.FRACTION_BITS(FRACTION_BITS)) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (f_valid),
        .in_ready  (f_ready),
        .in_data   (f_data),
        .out_valid (c_valid),
        .out_ready (c_ready),
        .out_data  (c_data)
    );

    cau_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (c_valid),
        .in_ready    (c_ready),
        .in_data     (c_data),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .result_real (result_real),
        .result_imag (result_imag),
        .status      (m_tuser)
    );

    assign m_tdata = {result_imag, result_real};

endmodule
